>>> rtl/core/tournament_hamiltonian_cycle_core_macros.svh
// Assertion macros for the tournament Hamiltonian cycle core.
// Included by the checker; depends on nothing else.
`ifndef TOURNAMENT_HAMILTONIAN_CYCLE_CORE_MACROS_SVH
`define TOURNAMENT_HAMILTONIAN_CYCLE_CORE_MACROS_SVH
// Assert that a condition implies a consequence on the same edge.
`define THC_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Assert that a condition implies a consequence on the next edge.
`define THC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/core/thc_pkg.sv
// Package for the tournament Hamiltonian cycle core: types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package thc_pkg;
  localparam int unsigned VC_W = 6;
  localparam int unsigned ROW_W = 32;
  localparam int unsigned IDX_W = 5;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // Datapath operations commanded by the controller.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_INIT   = 4'd1,  // start path build
    OP_INS    = 4'd2,  // scan one path position during insertion
    OP_PREFIX = 4'd3,  // scan for initial cycle prefix
    OP_SPLICE = 4'd4,  // scan cycle for splice point
    OP_ROT    = 4'd5,  // rotate cycle one step
    OP_EMIT   = 4'd6   // hold emit state
  } op_t;

  typedef struct packed {
    op_t op;
  } thc_cmd_t;

  typedef struct packed {
    logic done;    // current phase finishes at this edge
    logic fail;    // no cycle
    logic single;  // one vertex
    logic spliced; // a segment is spliced at this edge, rotation follows
  } thc_stat_t;
endpackage
`default_nettype wire

>>> rtl/core/thc_if.sv
// Valid/ready channel interfaces for the core's input and output channels.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface thc_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [4:0] row_index;
  logic [31:0] row_bits;
  modport source (output valid, cmd, row_index, row_bits, input ready);
  modport sink (input valid, cmd, row_index, row_bits, output ready);
endinterface

interface thc_out_if;
  logic valid;
  logic ready;
  logic [5:0] vertex;
  logic last_vertex;
  logic no_cycle;
  modport source (output valid, vertex, last_vertex, no_cycle, input ready);
  modport sink (input valid, vertex, last_vertex, no_cycle, output ready);
endinterface
`default_nettype wire

>>> rtl/core/thc_datapath.sv
// Datapath: adjacency rows, path sequence registers and the build steps.
// Depends on thc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module thc_datapath #(
  parameter int unsigned MAX_V = 32
) (
  input  wire logic clk,
  input  wire logic load_en,
  input  wire logic [4:0] load_idx,
  input  wire logic [31:0] load_bits,
  input  wire logic [5:0] n_cfg,
  input  wire thc_pkg::thc_cmd_t cmd,
  input  wire logic emit_adv,
  output thc_pkg::thc_stat_t stat,
  output logic [5:0] emit_vertex,
  output logic emit_last
);
  localparam int unsigned SW = $clog2(MAX_V);
  localparam int unsigned CW = $clog2(MAX_V + 1);
  localparam logic [5:0] VC_MAX = 6'(MAX_V > 63 ? 63 : MAX_V);

  logic [31:0] adj [MAX_V];
  logic [SW-1:0] seq [MAX_V];
  logic [CW-1:0] n, len, u, p, k, cl, j, i, rot, ep;

  // a beats b
  function automatic logic beats(input logic [31:0] ra, input logic [31:0] rb,
                                 input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic r;
    r = 1'b0;
    if (a == b) r = 1'b0;
    else if (b < a) r = (32'(b) < 32) ? ra[5'(b)] : 1'b0;
    else r = (32'(a) < 32) ? !rb[5'(a)] : 1'b1;
    return r;
  endfunction

  function automatic logic bt(input logic [SW-1:0] a, input logic [SW-1:0] b,
                              input logic [31:0] ra, input logic [31:0] rb);
    return beats(ra, rb, a, b);
  endfunction

  // operands for the single comparator
  logic [SW-1:0] ca, cb;
  logic cres;
  always_comb begin
    ca = '0;
    cb = '0;
    case (cmd.op)
      thc_pkg::OP_INS:    begin ca = seq[p[SW-1:0]]; cb = u[SW-1:0]; end
      thc_pkg::OP_PREFIX: begin ca = seq[k[SW-1:0]]; cb = seq[0]; end
      thc_pkg::OP_SPLICE: begin ca = seq[j[SW-1:0]]; cb = seq[i[SW-1:0]]; end
      thc_pkg::OP_ROT:    begin ca = seq[cl[SW-1:0] - 1'b1]; cb = seq[cl[SW-1:0]]; end
      default: ;
    endcase
    cres = bt(ca, cb, adj[ca], adj[cb]);
  end

  logic [CW-1:0] nsat;
  assign nsat = (n_cfg > (VC_MAX)) ? CW'(MAX_V) : CW'(n_cfg);

  // phase status, valid in the cycle whose edge ends the phase
  logic done_c, fail_c, splice_c, fail_r;
  always_comb begin
    done_c = 1'b0;
    fail_c = 1'b0;
    splice_c = 1'b0;
    case (cmd.op)
      thc_pkg::OP_INS: done_c = !(p < len && cres) && (u + 1'b1 == n);
      thc_pkg::OP_PREFIX: begin
        fail_c = (k >= n);
        done_c = (k < n) && cres;
      end
      thc_pkg::OP_SPLICE: begin
        done_c = (j >= n);
        fail_c = (j >= n) && (cl < n);
        splice_c = (j < n) && (i != cl) && cres;
      end
      thc_pkg::OP_ROT: done_c = (cl >= n) || (rot >= cl) || cres;
      default: ;
    endcase
  end

  assign stat.done = done_c;
  assign stat.fail = fail_r || fail_c;
  assign stat.single = (nsat == CW'(1));
  assign stat.spliced = splice_c;

  always_ff @(posedge clk) begin
    if (load_en && (32'(load_idx) < MAX_V)) adj[SW'(load_idx)] <= load_bits;
    case (cmd.op)
      thc_pkg::OP_INIT: begin
        n <= nsat; len <= '0; u <= '0; p <= '0; fail_r <= 1'b0; ep <= '0;
        if (nsat == CW'(1)) seq[0] <= '0;
        else if (nsat < CW'(3)) fail_r <= 1'b1;
      end
      thc_pkg::OP_INS: begin
        if (p < len && cres) p <= p + 1'b1;
        else begin
          // shift tail right one slot and insert (register moves)
          for (int x = MAX_V - 1; x > 0; x--)
            if (CW'(x) > p && CW'(x) <= len) seq[x] <= seq[x-1];
          seq[p[SW-1:0]] <= u[SW-1:0];
          len <= len + 1'b1;
          p <= '0;
          if (u + 1'b1 == n) k <= CW'(2);
          u <= u + 1'b1;
        end
      end
      thc_pkg::OP_PREFIX: begin
        if (k >= n) ;
        else if (cres) begin
          cl <= k + 1'b1; j <= k + 1'b1; i <= '0;
        end else k <= k + 1'b1;
      end
      thc_pkg::OP_SPLICE: begin
        if (j >= n) ;
        else if (i == cl) begin j <= j + 1'b1; i <= '0; end
        else if (cres) begin
          // move seq[cl..j] in front of position i: rotate right [i..j] by j-cl+1
          for (int x = 0; x < MAX_V; x++) begin
            if (CW'(x) >= i && CW'(x) <= j) begin
              if (CW'(x) < i + (j - cl + 1'b1))
                seq[x] <= seq[SW'(CW'(x) - i + cl)];
              else
                seq[x] <= seq[SW'(CW'(x) - (j - cl + 1'b1))];
            end
          end
          cl <= j + 1'b1; j <= j + 1'b1; i <= '0; rot <= '0;
        end else i <= i + 1'b1;
      end
      thc_pkg::OP_ROT: begin
        if (!(cl >= n || rot >= cl || cres)) begin
          for (int x = 1; x < MAX_V; x++)
            if (CW'(x) < cl) seq[x] <= seq[x-1];
          seq[0] <= seq[cl[SW-1:0] - 1'b1];
          rot <= rot + 1'b1;
        end
      end
      thc_pkg::OP_EMIT: if (emit_adv) ep <= ep + 1'b1;
      default: ;
    endcase
  end

  assign emit_vertex = 6'(seq[ep[SW-1:0]]) + 6'd1;
  assign emit_last = (ep + 1'b1 == n) || (n == CW'(1));
endmodule
`default_nettype wire

>>> rtl/core/thc_ctrl.sv
// Controller state machine sequencing load, build, splice and emit.
// Depends on thc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module thc_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_cmd,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  output logic out_err,
  input  wire logic emit_last,
  input  wire thc_pkg::thc_stat_t stat,
  output thc_pkg::thc_cmd_t cmd,
  output logic emit_adv,
  output logic load_en
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_INIT = 7'b0000010, S_INS = 7'b0000100,
    S_PRE = 7'b0001000, S_SPL = 7'b0010000, S_ROT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;
  state_t state, state_next;
  logic err, err_next;

  assign in_ready = (state == S_IDLE);
  assign load_en = in_valid && in_ready && (in_cmd == thc_pkg::CMD_LOAD);
  assign out_valid = (state == S_EMIT);
  assign out_err = err;
  assign emit_adv = out_valid && out_ready;

  always_comb begin
    state_next = state;
    err_next = err;
    cmd.op = thc_pkg::OP_NONE;
    case (state)
      S_IDLE: if (in_valid && in_cmd == thc_pkg::CMD_SOLVE) state_next = S_INIT;
      S_INIT: begin
        cmd.op = thc_pkg::OP_INIT;
        state_next = S_INS; err_next = 1'b0;
      end
      S_INS: begin
        cmd.op = thc_pkg::OP_INS;
        if (stat.single) state_next = S_EMIT;
        else if (stat.fail) begin err_next = 1'b1; state_next = S_EMIT; end
        else if (stat.done) state_next = S_PRE;
      end
      S_PRE: begin
        cmd.op = thc_pkg::OP_PREFIX;
        if (stat.fail) begin err_next = 1'b1; state_next = S_EMIT; end
        else if (stat.done) state_next = S_SPL;
      end
      S_SPL: begin
        cmd.op = thc_pkg::OP_SPLICE;
        if (stat.done) begin
          err_next = stat.fail; state_next = S_EMIT;
        end else if (stat.spliced) state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = thc_pkg::OP_ROT;
        if (stat.done) state_next = S_SPL;
      end
      S_EMIT: begin
        cmd.op = thc_pkg::OP_EMIT;
        if (emit_adv && (err || emit_last)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin state <= S_IDLE; err <= 1'b0; end
    else begin state <= state_next; err <= err_next; end
  end
endmodule
`default_nettype wire

>>> rtl/core/tournament_hamiltonian_cycle_core.sv
// Top level of the tournament Hamiltonian cycle core.
// Depends on thc_pkg, thc_if, thc_ctrl and thc_datapath.
//
// channel  | dir | payload
// in       | in  | cmd, row_index, row_bits
// out      | out | vertex, last_vertex, no_cycle
// cfg      | in  | cfg_we, cfg_data (vertex_count)
//
// Row loads can follow one a cycle while the core is idle. A solve runs a
// set-up step, then insertion, which compares path positions, then prefix,
// splice and rotation steps at one comparison a cycle through the same
// single edge comparator. Results then leave one a cycle while out.ready
// is high; stalls hold them, and the input is held off until the last result
// of the solve has left.
// Reset (rst, synchronous) returns to idle with vertex_count 1.
`timescale 1ns / 1ps
`default_nettype none
module tournament_hamiltonian_cycle_core #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input wire logic clk,
  input wire logic rst,
  thc_in_if.sink in,
  thc_out_if.source out,
  input wire logic cfg_we,
  input wire logic [5:0] cfg_data
);
  logic [5:0] vertex_count;
  thc_pkg::thc_stat_t stat;
  thc_pkg::thc_cmd_t cmd;
  logic emit_adv, load_en, emit_last, err;
  logic [5:0] emit_vertex;

  // hold the configured vertex count
  always_ff @(posedge clk) begin
    if (rst) vertex_count <= 6'd1;
    else if (cfg_we) vertex_count <= cfg_data;
  end

  thc_ctrl u_ctrl (
    .clk, .rst, .in_valid(in.valid), .in_cmd(in.cmd), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .out_err(err),
    .emit_last, .stat, .cmd, .emit_adv, .load_en
  );

  thc_datapath #(.MAX_V(MAX_VERTICES)) u_dp (
    .clk, .load_en, .load_idx(in.row_index), .load_bits(in.row_bits),
    .n_cfg(vertex_count), .cmd, .emit_adv, .stat, .emit_vertex, .emit_last
  );

  // error result carries vertex 0
  assign out.vertex = err ? 6'd0 : emit_vertex;
  assign out.last_vertex = err ? 1'b0 : emit_last;
  assign out.no_cycle = err;
endmodule
`default_nettype wire

>>> rtl/core/thc_checker.sv
// Port checker for the tournament Hamiltonian cycle core, with its bind.
// Depends on the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "tournament_hamiltonian_cycle_core_macros.svh"
module thc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [5:0] vertex,
  input wire logic no_cycle,
  input wire logic last_vertex
);
  `THC_ASSERT_IMP(a_err_zero, clk, rst, out_valid && no_cycle, vertex == 6'd0 && !last_vertex, "error item must carry vertex 0")
  `THC_ASSERT_IMP(a_ok_nonzero, clk, rst, out_valid && !no_cycle, vertex != 6'd0, "cycle vertex must be non-zero")
  `THC_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready, "no input taken while emitting")
  `THC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(vertex), "stalled item must hold")
endmodule

bind tournament_hamiltonian_cycle_core thc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .vertex(out.vertex),
  .no_cycle(out.no_cycle), .last_vertex(out.last_vertex)
);
`default_nettype wire
